/* design/slt_pkg.sv */
// Shared types and constants for the station learning table.
// No dependencies; imported by slt_front, slt_back, the top unit and the testbench.
package slt_pkg;

	localparam int MAC_W  = 48;
	localparam int TIME_W = 32;
	localparam int RSSI_W = 8;

	// bit positions in the first octet of an address
	localparam int GROUP_BIT = 40;
	localparam int LOCAL_BIT = 41;

	localparam logic [RSSI_W-1:0] RSSI_FLOOR = 8'h80;

	localparam logic [1:0] REQ_PLAIN = 2'd0;
	localparam logic [1:0] REQ_PROBE = 2'd1;
	localparam logic [1:0] REQ_ASSOC = 2'd2;
	localparam logic [1:0] REQ_CLEAR = 2'd3;

	typedef enum logic [1:0] {
		K_FRAME,
		K_IGNORE,
		K_CLEAR
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		kind_t             kind;
		logic              probe;
		logic              assoc;
		logic [MAC_W-1:0]  mac;
		logic [RSSI_W-1:0] rssi;
		logic [TIME_W-1:0] now_ms;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} qhead_t;

	// flags: bit 1 associated, bit 0 randomised
	typedef struct packed {
		logic [MAC_W-1:0]  mac;
		logic [TIME_W-1:0] last_seen;
		logic [31:0]       frames;
		logic [15:0]       probes;
		logic [RSSI_W-1:0] last_rssi;
		logic [RSSI_W-1:0] best_rssi;
		logic [1:0]        flags;
	} entry_t;

	typedef struct packed {
		logic              accepted;
		logic [4:0]        slot;
		logic              was_new;
		logic              evicted;
		logic [31:0]       frame_count;
		logic [15:0]       probe_count;
		logic [RSSI_W-1:0] last_rssi;
		logic [RSSI_W-1:0] best_rssi;
		logic              randomised;
		logic              associated;
		logic [5:0]        station_count;
		logic [31:0]       dropped_total;
	} res_t;

endpackage

/* design/slt_ram.sv */
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module slt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

/* design/slt_front.sv */
// Front end: accepts beats, classifies them and holds them in a two-entry queue.
// Depends on slt_pkg.
module slt_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  req_type,
	input  logic [slt_pkg::MAC_W-1:0]   mac,
	input  logic signed [7:0]           rssi,
	input  logic [slt_pkg::TIME_W-1:0]  now_ms,
	input  logic [slt_pkg::MAC_W-1:0]   bssid,
	output slt_pkg::qhead_t             head,
	input  logic                        pop
);
	import slt_pkg::*;

	item_t      slots_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	item_t      cls;

	always_comb begin
		cls.kind = (req_type == REQ_CLEAR) ? K_CLEAR :
			(mac[GROUP_BIT] ? K_IGNORE : K_FRAME);
		cls.probe  = (req_type == REQ_PROBE);
		cls.assoc  = (req_type == REQ_ASSOC) && !bssid[GROUP_BIT];
		cls.mac    = mac;
		cls.rssi   = rssi;
		cls.now_ms = now_ms;
	end

	assign in_stall   = (count_q == 2'd2);
	assign push       = in_valid && !in_stall;
	assign head.valid = (count_q != 2'd0);
	assign head.item  = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end
endmodule

/* design/slt_back.sv */
// Back end: scans the station table, picks hit, free or oldest slot, updates it.
// Depends on slt_pkg and slt_ram.
module slt_back #(
	parameter int MAX_STATIONS = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  slt_pkg::qhead_t head,
	output logic            pop,
	output slt_pkg::res_t   res,
	output logic            out_valid,
	input  logic            out_stall
);
	import slt_pkg::*;

	localparam int IW = $clog2(MAX_STATIONS);
	localparam int CW = $clog2(MAX_STATIONS + 1);

	state_t            state_q, state_d;
	item_t             cur_q;
	logic [CW-1:0]     used_q, rd_q;
	logic [31:0]       drop_q;
	logic              cmp_v_s1;
	logic [IW-1:0]     cmp_idx_s1;
	logic              found_q;
	logic [IW-1:0]     hit_idx_q, min_idx_q;
	entry_t            hit_word_q;
	logic [TIME_W-1:0] min_ts_q;
	logic              out_valid_q;
	res_t              res_q;

	entry_t        rdata, fresh, base, upd;
	logic          issue, hit, scan_done, out_free, start, finish, full;
	logic          is_new, evict;
	logic [IW-1:0] idx;
	logic [CW-1:0] used_d;
	logic [31:0]   drop_d;
	logic [IW+4:0] slot_ext;
	logic [CW+5:0] cnt_ext;
	res_t          res_d;
	logic [$bits(entry_t)-1:0] rdata_raw;

	slt_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(MAX_STATIONS)
	) u_table (
		.clk  (clk),
		.we   (finish && (cur_q.kind == K_FRAME)),
		.waddr(idx),
		.wdata(upd),
		.re   (issue),
		.raddr(rd_q[IW-1:0]),
		.rdata(rdata_raw)
	);
	assign rdata = rdata_raw;

	assign issue     = (state_q == ST_SCAN) && (rd_q < used_q);
	assign hit       = cmp_v_s1 && (rdata.mac == cur_q.mac);
	assign scan_done = hit || (!issue && !cmp_v_s1);
	assign out_free  = !out_valid_q || !out_stall;
	assign start     = (state_q == ST_IDLE) && head.valid;
	assign finish    = (state_q == ST_FINISH) && out_free;
	assign full      = (used_q == CW'(MAX_STATIONS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (head.valid) begin
					pop = 1'b1;
					if (head.item.kind == K_FRAME && used_q != '0) begin
						state_d = ST_SCAN;
					end else begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_SCAN: begin
				if (scan_done) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// pick the slot, build the updated entry and the result
	always_comb begin
		fresh.mac       = cur_q.mac;
		fresh.last_seen = cur_q.now_ms;
		fresh.frames    = '0;
		fresh.probes    = '0;
		fresh.last_rssi = '0;
		fresh.best_rssi = RSSI_FLOOR;
		fresh.flags     = {1'b0, cur_q.mac[LOCAL_BIT]};

		is_new = !found_q;
		evict  = !found_q && full;
		if (found_q) begin
			idx  = hit_idx_q;
			base = hit_word_q;
		end else if (full) begin
			idx  = min_idx_q;
			base = fresh;
		end else begin
			idx  = used_q[IW-1:0];
			base = fresh;
		end

		upd           = base;
		upd.last_seen = cur_q.now_ms;
		if (base.frames != '1) begin
			upd.frames = base.frames + 32'd1;
		end
		if (cur_q.rssi != '0) begin
			upd.last_rssi = cur_q.rssi;
			if ($signed(cur_q.rssi) > $signed(base.best_rssi)) begin
				upd.best_rssi = cur_q.rssi;
			end
		end
		if (cur_q.probe && base.probes != '1) begin
			upd.probes = base.probes + 16'd1;
		end
		if (cur_q.assoc) begin
			upd.flags[1] = 1'b1;
		end

		used_d = used_q;
		drop_d = drop_q;
		res_d  = '0;
		unique case (cur_q.kind)
			K_CLEAR: begin
				used_d = '0;
				drop_d = '0;
			end
			K_IGNORE: begin
			end
			K_FRAME: begin
				if (is_new && !full) begin
					used_d = used_q + CW'(1);
				end
				if (evict && drop_q != '1) begin
					drop_d = drop_q + 32'd1;
				end
				res_d.accepted    = 1'b1;
				res_d.was_new     = is_new;
				res_d.evicted     = evict;
				res_d.frame_count = upd.frames;
				res_d.probe_count = upd.probes;
				res_d.last_rssi   = upd.last_rssi;
				res_d.best_rssi   = upd.best_rssi;
				res_d.randomised  = upd.flags[0];
				res_d.associated  = upd.flags[1];
			end
			default: begin
			end
		endcase
		slot_ext = {5'd0, idx};
		cnt_ext  = {6'd0, used_d};
		if (cur_q.kind == K_FRAME) begin
			res_d.slot = slot_ext[4:0];
		end
		res_d.station_count = cnt_ext[5:0];
		res_d.dropped_total = drop_d;
	end

	always_ff @(posedge clk) begin
		if (start) begin
			cur_q     <= head.item;
			min_ts_q  <= '1;
			min_idx_q <= '0;
		end
		cmp_idx_s1 <= rd_q[IW-1:0];
		if (state_q == ST_SCAN && cmp_v_s1 && !found_q) begin
			if (hit) begin
				hit_idx_q  <= cmp_idx_s1;
				hit_word_q <= rdata;
			end else if (rdata.last_seen < min_ts_q) begin
				min_ts_q  <= rdata.last_seen;
				min_idx_q <= cmp_idx_s1;
			end
		end
		if (finish) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q        <= '0;
			cmp_v_s1    <= 1'b0;
			found_q     <= 1'b0;
			used_q      <= '0;
			drop_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			cmp_v_s1 <= issue;
			if (start) begin
				rd_q    <= '0;
				found_q <= 1'b0;
			end else if (issue) begin
				rd_q <= rd_q + CW'(1);
			end
			if (state_q == ST_SCAN && hit) begin
				found_q <= 1'b1;
			end
			if (finish) begin
				used_q      <= used_d;
				drop_q      <= drop_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;
endmodule

/* design/station_learning_table_unit.sv */
// Station learning table: one result beat per input beat. A frame item scans
// the N stations in use (at most MAX_STATIONS) when N is nonzero: the table
// lives in one RAM and its read port is swept one entry per cycle to find the
// match and the oldest entry together, stopping early on a hit. Clear and
// group-address items, and frames into an empty table, skip the scan. A
// two-beat queue sits in front of the scan, and the result register lets the
// next item proceed while a result waits.
module station_learning_table_unit #(
	parameter int MAX_STATIONS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  req_type,
	input  logic [slt_pkg::MAC_W-1:0]   mac,
	input  logic signed [7:0]           rssi,
	input  logic [slt_pkg::TIME_W-1:0]  now_ms,
	input  logic [slt_pkg::MAC_W-1:0]   bssid,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        accepted,
	output logic [4:0]                  slot,
	output logic                        was_new,
	output logic                        evicted,
	output logic [31:0]                 frame_count,
	output logic [15:0]                 probe_count,
	output logic signed [7:0]           last_rssi,
	output logic signed [7:0]           best_rssi,
	output logic                        randomised,
	output logic                        associated,
	output logic [5:0]                  station_count,
	output logic [31:0]                 dropped_total
);
	import slt_pkg::*;

	qhead_t head;
	logic   pop;
	res_t   res;

	slt_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.mac     (mac),
		.rssi    (rssi),
		.now_ms  (now_ms),
		.bssid   (bssid),
		.head    (head),
		.pop     (pop)
	);

	slt_back #(
		.MAX_STATIONS(MAX_STATIONS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.pop      (pop),
		.res      (res),
		.out_valid(out_valid),
		.out_stall(out_stall)
	);

	assign accepted      = res.accepted;
	assign slot          = res.slot;
	assign was_new       = res.was_new;
	assign evicted       = res.evicted;
	assign frame_count   = res.frame_count;
	assign probe_count   = res.probe_count;
	assign last_rssi     = res.last_rssi;
	assign best_rssi     = res.best_rssi;
	assign randomised    = res.randomised;
	assign associated    = res.associated;
	assign station_count = res.station_count;
	assign dropped_total = res.dropped_total;

`ifndef NO_ASSERTIONS
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !accepted |-> slot == 5'd0 && frame_count == 32'd0 && !was_new)
		else $error("rejected beat carries entry data");
	a_frame_counted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && accepted |-> frame_count != 32'd0)
		else $error("accepted beat with zero frame count");
	a_evict_new: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && evicted |-> was_new && accepted)
		else $error("eviction without a new entry");
`endif
endmodule

/* dv/tb.sv */
// Testbench for station_learning_table_unit: directed and random frame streams,
// checked beat by beat against a behavioral table model. Depends on slt_pkg.
`timescale 1ns / 100ps

module tb;
	import slt_pkg::*;

	localparam int N_SLOTS = 32;
	localparam longint unsigned CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [1:0]  req;
		logic [47:0] mac;
		logic [7:0]  rssi;
		logic [31:0] now_ms;
		logic [47:0] bssid;
	} frame_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [1:0] req_type = REQ_PLAIN;
	logic [47:0] mac = '0;
	logic signed [7:0] rssi = '0;
	logic [31:0] now_ms = '0;
	logic [47:0] bssid = '0;
	logic out_valid;
	logic out_stall = 0;
	logic accepted, was_new, evicted, randomised, associated;
	logic [4:0] slot;
	logic [31:0] frame_count, dropped_total;
	logic [15:0] probe_count;
	logic signed [7:0] last_rssi, best_rssi;
	logic [5:0] station_count;

	station_learning_table_unit u_top (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// station table copy
	entry_t tbl [N_SLOTS];
	int unsigned n_used;
	logic [31:0] n_evict;
	res_t expected_q[$];
	int errors = 0;
	int n_results = 0;
	longint unsigned cycles = 0;
	int stall_max = 3;
	logic [31:0] clock_ms = 0;
	logic [47:0] pool [8];

	function automatic res_t learn_frame(frame_t f);
		res_t r;
		int idx;
		bit hit;
		r = '0;
		idx = 0;
		hit = 0;
		if (f.req == REQ_CLEAR) begin
			n_used = 0;
			n_evict = 0;
		end else if (!f.mac[GROUP_BIT]) begin
			for (int i = 0; i < n_used; i++)
				if (!hit && tbl[i].mac == f.mac) begin
					idx = i;
					hit = 1;
				end
			if (!hit) begin
				r.was_new = 1;
				if (n_used >= N_SLOTS) begin
					idx = 0;
					for (int i = 1; i < N_SLOTS; i++)
						if (tbl[i].last_seen < tbl[idx].last_seen)
							idx = i;
					r.evicted = 1;
					if (n_evict != 32'hFFFF_FFFF)
						n_evict++;
				end else begin
					idx = n_used;
					n_used++;
				end
				tbl[idx] = '0;
				tbl[idx].mac = f.mac;
				tbl[idx].best_rssi = RSSI_FLOOR;
				tbl[idx].flags[0] = f.mac[LOCAL_BIT];
			end
			if (tbl[idx].frames != 32'hFFFF_FFFF)
				tbl[idx].frames++;
			tbl[idx].last_seen = f.now_ms;
			if (f.rssi != 0) begin
				tbl[idx].last_rssi = f.rssi;
				if ($signed(f.rssi) > $signed(tbl[idx].best_rssi))
					tbl[idx].best_rssi = f.rssi;
			end
			if (f.req == REQ_PROBE && tbl[idx].probes != 16'hFFFF)
				tbl[idx].probes++;
			if (f.req == REQ_ASSOC && !f.bssid[GROUP_BIT])
				tbl[idx].flags[1] = 1;
			r.accepted = 1;
			r.slot = idx[4:0];
			r.frame_count = tbl[idx].frames;
			r.probe_count = tbl[idx].probes;
			r.last_rssi = tbl[idx].last_rssi;
			r.best_rssi = tbl[idx].best_rssi;
			r.randomised = tbl[idx].flags[0];
			r.associated = tbl[idx].flags[1];
		end
		r.station_count = n_used[5:0];
		r.dropped_total = n_evict;
		return r;
	endfunction

	function automatic int gap_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
	endfunction

	// valid stays up across back-to-back beats; it drops only for a gap
	task automatic send_frame(frame_t f, int gap = -1);
		int g;
		g = (gap < 0) ? gap_len() : gap;
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(negedge clk);
		end
		in_valid <= 1;
		req_type <= f.req;
		mac <= f.mac;
		rssi <= f.rssi;
		now_ms <= f.now_ms;
		bssid <= f.bssid;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		expected_q.push_back(learn_frame(f));
		@(negedge clk);
	endtask

	function automatic frame_t mk(logic [1:0] rq, logic [47:0] m, logic [7:0] s,
			logic [31:0] t, logic [47:0] b);
		frame_t f;
		f.req = rq; f.mac = m; f.rssi = s; f.now_ms = t; f.bssid = b;
		return f;
	endfunction

	function automatic logic [47:0] rand48();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[47:0];
	endfunction

	// unicast address, random otherwise
	function automatic logic [47:0] ucast();
		logic [47:0] m;
		m = rand48();
		m[GROUP_BIT] = 0;
		return m;
	endfunction

	// receiver side: stall pattern and checker
	always @(negedge clk) begin
		if (stall_max == 0)
			out_stall <= 0;
		else if ($urandom_range(0, 19) == 0)
			out_stall <= 1'b1;
		else if ($urandom_range(0, stall_max) == 0)
			out_stall <= 0;
	end

	always @(posedge clk) begin
		res_t want;
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("tb NOT OK");
			$finish;
		end
		if (arst_n && out_valid && !out_stall) begin
			n_results++;
			if (expected_q.size() == 0) begin
				$display("%0t unexpected result beat", $realtime);
				errors++;
			end else begin
				want = expected_q.pop_front();
				if (want !== {accepted, slot, was_new, evicted, frame_count, probe_count,
						last_rssi, best_rssi, randomised, associated, station_count,
						dropped_total}) begin
					errors++;
					$display("%0t mismatch exp acc=%b slot=%0d new=%b ev=%b fc=%0d pc=%0d lr=%0d br=%0d rnd=%b as=%b sc=%0d dr=%0d",
						$realtime, want.accepted, want.slot, want.was_new, want.evicted,
						want.frame_count, want.probe_count, $signed(want.last_rssi),
						$signed(want.best_rssi), want.randomised, want.associated,
						want.station_count, want.dropped_total);
					$display("%0t          act acc=%b slot=%0d new=%b ev=%b fc=%0d pc=%0d lr=%0d br=%0d rnd=%b as=%b sc=%0d dr=%0d",
						$realtime, accepted, slot, was_new, evicted, frame_count,
						probe_count, last_rssi, best_rssi, randomised, associated,
						station_count, dropped_total);
				end
			end
		end
	end

	task automatic test_field_extremes();
		send_frame(mk(REQ_PLAIN, 48'h0, 8'h00, 32'h0, 48'h0));
		send_frame(mk(REQ_PLAIN, 48'h0, 8'h7F, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF));
		send_frame(mk(REQ_PROBE, 48'hFEFF_FFFF_FFFF, 8'h80, 32'h1, 48'h0));
		send_frame(mk(REQ_PROBE, 48'hFEFF_FFFF_FFFF, 8'h00, 32'h2, 48'h0));
		send_frame(mk(REQ_PLAIN, 48'hFFFF_FFFF_FFFF, 8'h10, 32'h3, 48'h0)); // group
		send_frame(mk(REQ_ASSOC, 48'h0200_0000_0001, 8'hC0, 32'h4, 48'h0100_0000_0000));
		send_frame(mk(REQ_ASSOC, 48'h0200_0000_0001, 8'hD0, 32'h5, 48'hFEFF_FFFF_FFFF));
		send_frame(mk(REQ_CLEAR, 48'h0000_0000_0001, 8'h55, 32'h6, 48'h0));
		send_frame(mk(REQ_PLAIN, 48'hAB00_0000_0001, 8'hFF, 32'h7, 48'h0));
	endtask

	// fill the table, then evict with tied and distinct ages
	task automatic test_eviction();
		send_frame(mk(REQ_CLEAR, 48'h0, 8'h0, 32'h0, 48'h0));
		for (int i = 0; i < N_SLOTS; i++)
			send_frame(mk(REQ_PLAIN, 48'h0000_0000_1000 + i, 8'hE0, 32'd100, 48'h0), 0);
		send_frame(mk(REQ_PLAIN, 48'h0000_0000_2000, 8'hE0, 32'd50, 48'h0));
		send_frame(mk(REQ_PLAIN, 48'h0000_0000_2001, 8'hE0, 32'd200, 48'h0));
		send_frame(mk(REQ_PROBE, 48'h0000_0000_1005, 8'hE0, 32'd20, 48'h0));
		send_frame(mk(REQ_PLAIN, 48'h0000_0000_2002, 8'hE0, 32'd300, 48'h0));
	endtask

	task automatic test_random(int n);
		frame_t f;
		logic [31:0] t;
		for (int k = 0; k < n; k++) begin
			if (k % 200 == 0) stall_max = $urandom_range(0, 6);
			clock_ms += $urandom_range(0, 50);
			t = ($urandom_range(0, 15) == 0) ? $urandom : clock_ms;
			f.req = ($urandom_range(0, 150) == 0) ? REQ_CLEAR : 2'($urandom_range(0, 2));
			case ($urandom_range(0, 9))
				0: f.mac = rand48();
				1, 2: f.mac = ucast();
				default: f.mac = pool[$urandom_range(0, 7)] + 48'($urandom_range(0, 40));
			endcase
			f.rssi = ($urandom_range(0, 5) == 0) ? 8'h0 : 8'($urandom);
			f.now_ms = t;
			f.bssid = rand48();
			send_frame(f, (k % 300 < 40) ? 0 : -1);
		end
	endtask

	initial begin
		for (int i = 0; i < 8; i++) pool[i] = ucast() & 48'hFFFF_FFFF_FF00;
		n_used = 0;
		n_evict = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		test_field_extremes();
		test_eviction();
		test_random(1050);
		in_valid <= 0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		$display("ran directed extremes, table fill and eviction, and 1050 random frames");
		$display("%0d results checked, %0d errors", n_results, errors);
		if (errors == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end
endmodule
